// ===== sv/boltzmann_mismatch_statistics_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef BOLTZMANN_MISMATCH_STATISTICS_DEFINES_SVH
`define BOLTZMANN_MISMATCH_STATISTICS_DEFINES_SVH
`ifndef ASSERT_OFF
`define BMS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BMS_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BMS_ASSERT(label, clk, rst_n, prop)
`define BMS_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg
// Types and constants for the mismatch statistics block.
// ----------------------------------------------------------------------------
package bms_pkg;

  typedef struct packed {
    logic [7:0] mismatch_count;
    logic       last_item;
  } bms_in_t;

  typedef struct packed {
    logic [24:0] total_items;
    logic [24:0] valid_items;
    logic [7:0]  least_nonzero;
    logic [23:0] plain_mean;
    logic [23:0] weighted_mean;
    logic [16:0] valid_fraction;
    logic [16:0] weighted_valid_fraction;
    logic [48:0] partition_value;
    logic [24:0] one_away;
    logic [24:0] two_away;
  } bms_out_t;

  localparam int unsigned DivNumBits = 81;
  localparam int unsigned DivDenBits = 57;

  // Divider job: numerator, denominator, and saturation cap.
  typedef struct packed {
    logic [DivNumBits-1:0] num;
    logic [DivDenBits-1:0] den;
    logic                  frac_cap;
  } bms_div_req_t;

endpackage

// ===== sv/bms_divider.sv =====
// ----------------------------------------------------------------------------
// bms_divider
// Restoring divider, one quotient bit per cycle, Q.16 result with saturation.
// ----------------------------------------------------------------------------
module bms_divider import bms_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  bms_div_req_t req_i,
  output logic         done_o,
  output logic [23:0]  quot_o
);

  localparam int unsigned CntBits = $clog2(DivNumBits + 1);

  logic [DivNumBits-1:0] num_q, num_d;
  logic [DivDenBits:0]   rem_q, rem_d;
  logic [DivDenBits-1:0] den_q, den_d;
  logic [DivNumBits-1:0] quo_q, quo_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  busy_q, busy_d, cap_q, cap_d, done_q, done_d;
  logic [DivDenBits:0]   trial;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; cap_d = cap_q; done_d = 1'b0;
    trial = {rem_q[DivDenBits-1:0], num_q[DivNumBits-1]};
    if (start_i) begin
      num_d = req_i.num; den_d = req_i.den; cap_d = req_i.frac_cap;
      rem_d = '0; quo_d = '0; busy_d = 1'b1;
      cnt_d = CntBits'(DivNumBits);
    end else if (busy_q) begin
      num_d = {num_q[DivNumBits-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[DivNumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DivNumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d; cap_q <= cap_d;
  end

  always_comb begin
    if (cap_q) begin
      quot_o = (quo_q > DivNumBits'(65536)) ? 24'd65536 : 24'(quo_q);
    end else begin
      quot_o = (quo_q > DivNumBits'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(quo_q);
    end
  end
  assign done_o = done_q;

endmodule

// ===== sv/bms_power_unit.sv =====
// ----------------------------------------------------------------------------
// bms_power_unit
// Square-and-multiply over the bits of the count on one shared multiplier.
// ----------------------------------------------------------------------------
module bms_power_unit #(
  parameter int unsigned WeightFracBits = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [7:0]            count_i,
  input  logic [WeightFracBits:0] base_i,
  output logic                  done_o,
  output logic [WeightFracBits:0] weight_o
);

  localparam logic [WeightFracBits:0] One = {1'b1, {WeightFracBits{1'b0}}};
  localparam int unsigned PW = 2 * (WeightFracBits + 1);

  logic [WeightFracBits:0] acc_q, acc_d, pow_q, pow_d;
  logic [7:0]              bits_q, bits_d;
  logic [3:0]              step_q, step_d;
  logic                    phase_q, phase_d, busy_q, busy_d, done_q, done_d;
  logic [WeightFracBits:0] opa;
  logic [PW-1:0]           prod;

  // Even phase multiplies the accumulator, odd phase squares the power.
  assign opa  = phase_q ? pow_q : acc_q;
  assign prod = {{(WeightFracBits+1){1'b0}}, opa} * {{(WeightFracBits+1){1'b0}}, pow_q};

  always_comb begin
    acc_d = acc_q; pow_d = pow_q; bits_d = bits_q; step_d = step_q;
    phase_d = phase_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = One;
      pow_d = (base_i > One) ? One : base_i;
      bits_d = count_i; step_d = '0; phase_d = 1'b0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!phase_q) begin
        if (bits_q[0]) acc_d = (WeightFracBits+1)'(prod >> WeightFracBits);
        phase_d = 1'b1;
      end else begin
        pow_d = (WeightFracBits+1)'(prod >> WeightFracBits);
        bits_d = bits_q >> 1;
        phase_d = 1'b0;
        step_d = step_q + 1'b1;
      end
      if (!phase_q && bits_q == 8'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; phase_q <= 1'b0; step_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; phase_q <= phase_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; pow_q <= pow_d; bits_q <= bits_d;
  end

  assign done_o   = done_q;
  assign weight_o = acc_q;

  `include "boltzmann_mismatch_statistics_defines.svh"
  `BMS_ASSERT(a_step_bound, clk_i, rst_ni, busy_q |-> step_q <= 4'd8)
  `BMS_ASSERT(a_acc_le_one, clk_i, rst_ni, done_q |-> acc_q <= One)

endmodule

// ===== sv/boltzmann_mismatch_statistics.sv =====
// An unmarked item finishes after the power unit runs a multiply and a squaring pass for
// each bit of the count up to its highest set bit, and the accumulators are updated.
// A marked item then divides for plain mean, valid fraction, weighted mean and weighted
// valid fraction, skipping the last two if the partition is zero; output waits on stall.
// Throughput: one item at a time; the input stalls until the item is finished.
// Reset: asynchronous active low; accumulators clear, weight_base = 73537.
// ----------------------------------------------------------------------------
// boltzmann_mismatch_statistics
// Accumulates mismatch statistics and Boltzmann weights; reports per set.
// ----------------------------------------------------------------------------
module boltzmann_mismatch_statistics import bms_pkg::*; #(
  parameter int unsigned COUNT_BITS       = 24,
  parameter int unsigned WEIGHT_FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  bms_in_t     in_data_i,
  output logic        out_valid,
  input  logic        out_stall,
  output bms_out_t    out_data_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [24:0] cfg_data_i
);

  localparam logic [24:0] TallyCap = 25'(1) << COUNT_BITS;
  localparam int unsigned WB = WEIGHT_FRAC_BITS + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPow  = 3'd1;
  localparam logic [2:0] StAcc  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StWait = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [24:0] base_q;
  logic [24:0] items_q, zeros_q, ones_q, twos_q;
  logic [7:0]  min_q, m_q;
  logic        last_q;
  logic [31:0] psum_q;
  logic [48:0] wsum_q;
  logic [56:0] ssum_q;
  logic [1:0]  div_idx_q;
  logic [23:0] pm_q, wm_q, vf_q, wvf_q;
  logic        out_valid_q;
  logic        out_free;
  logic        pow_done, div_done, div_start, pow_start;
  logic [WB-1:0] weight;
  logic [23:0] quot;
  bms_div_req_t div_req;
  logic [48:0] w49;
  logic [49:0] wsum_add;
  logic [57:0] ssum_add;
  logic [32:0] psum_add;
  logic [56:0] mw;

  // A pending configuration write goes ahead of a new item.
  assign in_stall  = (state_q != StIdle) || cfg_valid;
  assign cfg_ready = (state_q == StIdle);
  assign pow_start = in_valid && !in_stall;
  assign out_free  = !out_valid_q || !out_stall;

  bms_power_unit #(.WeightFracBits(WEIGHT_FRAC_BITS)) u_pow (
    .clk_i, .rst_ni, .start_i(pow_start), .count_i(in_data_i.mismatch_count),
    .base_i(WB'(base_q)), .done_o(pow_done), .weight_o(weight)
  );

  bms_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .req_i(div_req),
    .done_o(div_done), .quot_o(quot)
  );

  assign w49      = 49'(weight);
  assign mw       = 57'({8'd0, weight} * {{WB{1'b0}}, m_q});
  assign wsum_add = {1'b0, wsum_q} + {1'b0, w49};
  assign ssum_add = {1'b0, ssum_q} + {1'b0, mw};
  assign psum_add = {1'b0, psum_q} + 33'(m_q);

  always_comb begin
    div_req = '0;
    unique case (div_idx_q)
      2'd0: div_req = '{num: 81'(psum_q) << 16, den: 57'(items_q), frac_cap: 1'b0};
      2'd1: div_req = '{num: 81'(zeros_q) << 16, den: 57'(items_q), frac_cap: 1'b1};
      2'd2: div_req = '{num: 81'(ssum_q) << 16, den: 57'(wsum_q), frac_cap: 1'b0};
      default: div_req = '{num: (81'(zeros_q) << WEIGHT_FRAC_BITS) << 16,
                           den: 57'(wsum_q), frac_cap: 1'b1};
    endcase
  end

  assign div_start = (state_q == StDiv);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (pow_start) state_d = StPow;
      StPow:  if (pow_done) state_d = StAcc;
      StAcc:  state_d = last_q ? StDiv : StIdle;
      StDiv:  state_d = (div_idx_q[1] && wsum_q == '0) ? StOut : StWait;
      StWait: if (div_done) state_d = (div_idx_q == 2'd3) ? StOut : StDiv;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; base_q <= 25'd73537; out_valid_q <= 1'b0;
      items_q <= '0; zeros_q <= '0; ones_q <= '0; twos_q <= '0;
      min_q <= '0; psum_q <= '0; wsum_q <= '0; ssum_q <= '0; div_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) base_q <= cfg_data_i;
      if (state_q == StOut && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
      if (pow_start) begin
        items_q <= (items_q < TallyCap) ? items_q + 1'b1 : TallyCap;
        if (in_data_i.mismatch_count == 8'd0)
          zeros_q <= (zeros_q < TallyCap) ? zeros_q + 1'b1 : TallyCap;
        else if (in_data_i.mismatch_count == 8'd1)
          ones_q <= (ones_q < TallyCap) ? ones_q + 1'b1 : TallyCap;
        else if (in_data_i.mismatch_count == 8'd2)
          twos_q <= (twos_q < TallyCap) ? twos_q + 1'b1 : TallyCap;
        if (in_data_i.mismatch_count != 8'd0 &&
            (min_q == 8'd0 || in_data_i.mismatch_count < min_q))
          min_q <= in_data_i.mismatch_count;
      end
      if (state_q == StAcc) begin
        psum_q <= psum_add[32] ? 32'hFFFFFFFF : psum_add[31:0];
        wsum_q <= wsum_add[49] ? '1 : wsum_add[48:0];
        ssum_q <= ssum_add[57] ? '1 : ssum_add[56:0];
        div_idx_q <= '0;
      end
      if (state_q == StWait && div_done) div_idx_q <= div_idx_q + 1'b1;
      if (state_q == StOut && out_free) begin
        items_q <= '0; zeros_q <= '0; ones_q <= '0; twos_q <= '0;
        min_q <= '0; psum_q <= '0; wsum_q <= '0; ssum_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pow_start) begin
      m_q <= in_data_i.mismatch_count;
      last_q <= in_data_i.last_item;
    end
    if (state_q == StDiv && div_idx_q[1] && wsum_q == '0) begin
      wm_q <= '0; wvf_q <= '0;
    end
    if (state_q == StWait && div_done) begin
      unique case (div_idx_q)
        2'd0: pm_q <= quot;
        2'd1: vf_q <= quot;
        2'd2: wm_q <= quot;
        default: wvf_q <= quot;
      endcase
    end
    if (state_q == StOut && out_free) begin
      out_data_o.total_items <= items_q;
      out_data_o.valid_items <= zeros_q;
      out_data_o.least_nonzero <= min_q;
      out_data_o.plain_mean <= pm_q;
      out_data_o.weighted_mean <= wm_q;
      out_data_o.valid_fraction <= 17'(vf_q);
      out_data_o.weighted_valid_fraction <= 17'(wvf_q);
      out_data_o.partition_value <= wsum_q << (24 - WEIGHT_FRAC_BITS);
      out_data_o.one_away <= ones_q;
      out_data_o.two_away <= twos_q;
    end
  end

  assign out_valid = out_valid_q;

  `include "boltzmann_mismatch_statistics_defines.svh"
  `BMS_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != StIdle) |-> !pow_start)
  `BMS_ASSERT(a_tally_cap, clk_i, rst_ni, items_q <= TallyCap)
  `BMS_ASSERT(a_cnt_order, clk_i, rst_ni, (zeros_q <= items_q) && (ones_q <= items_q))

endmodule
